FILE: hdl/hlkc_pkg.sv
// Shared types and constants for the hashed LRU key cache.
// No dependencies; the front end, the table engine and the top module import this package.
package hlkc_pkg;

    localparam int unsigned DEF_SLOTS      = 128;
    localparam int unsigned DEF_STAMP_BITS = 32;
    localparam int unsigned MAX_SLOT_BITS  = 12;
    localparam int unsigned SLOT_OUT_BITS  = 7;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // request codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] thickness;
        logic [31:0] colour;
    } t_key;

    typedef struct packed {
        logic                     req_type;
        t_key                     key;
        logic [MAX_SLOT_BITS-1:0] start;
    } t_req;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE_RD,
        B_PROBE_CHK,
        B_SCAN_RD,
        B_SCAN_CHK,
        B_WRITE,
        B_DONE
    } t_back_state;

endpackage

FILE: hdl/hlkc_if.sv
// Request and response channel interfaces (valid/ready) for the key cache.
// Depends on nothing but plain logic types.
interface hlkc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] radius;
    logic [15:0] thickness;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;

    modport source (output valid, req_type, radius, thickness, red, green, blue, alpha,
                    input ready);
    modport sink   (input valid, req_type, radius, thickness, red, green, blue, alpha,
                    output ready);
endinterface

interface hlkc_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [6:0] slot;
    logic       evicted;

    modport source (output valid, hit, slot, evicted, input ready);
    modport sink   (input valid, hit, slot, evicted, output ready);
endinterface

FILE: hdl/hlkc_front.sv
// Front end: takes request transfers, hashes a lookup's key with FNV-1a (one word a cycle)
// and reduces it to a start slot; a clear skips both. Depends on hlkc_pkg and hlkc_req_if.
module hlkc_front #(
    parameter int unsigned SLOTS = hlkc_pkg::DEF_SLOTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hlkc_req_if.sink          i_req,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output hlkc_pkg::t_req    o_push_data
);
    import hlkc_pkg::*;

    localparam int unsigned SLOT_BITS = $clog2(SLOTS);
    localparam bit          POW2      = ((SLOTS & (SLOTS - 1)) == 0);
    // floor(2^32 / SLOTS); the quotient estimate is at most one short
    localparam logic [31:0] RECIP     = 32'((64'd1 << 32) / 64'(SLOTS));

    t_front_state r_state, n_state;
    logic                 r_type, n_type;
    t_key                 r_key, n_key;
    logic [31:0]          r_h, n_h;
    logic [2:0]           r_step, n_step;
    logic [1:0]           r_phase, n_phase;
    logic [31:0]          r_q, n_q;
    logic [31:0]          r_r, n_r;
    logic [SLOT_BITS-1:0] r_rem, n_rem;

    logic [31:0]          w_word;
    logic [31:0]          w_h_next;
    logic [63:0]          w_prod;
    logic [31:0]          w_qs;
    logic [SLOT_BITS-1:0] w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_type  <= n_type;
        r_key   <= n_key;
        r_h     <= n_h;
        r_step  <= n_step;
        r_phase <= n_phase;
        r_q     <= n_q;
        r_r     <= n_r;
        r_rem   <= n_rem;
    end

    always_comb begin
        case (r_step)
            3'd0:    w_word = {16'd0, r_key.radius};
            3'd1:    w_word = {16'd0, r_key.thickness};
            3'd2:    w_word = {24'd0, r_key.colour[31:24]};
            3'd3:    w_word = {24'd0, r_key.colour[23:16]};
            3'd4:    w_word = {24'd0, r_key.colour[15:8]};
            default: w_word = {24'd0, r_key.colour[7:0]};
        endcase
        w_h_next = 32'((r_h ^ w_word) * FNV_PRIME);
        w_prod   = {32'd0, r_h} * {32'd0, RECIP};
        w_qs     = r_q * 32'(SLOTS);
        w_start  = POW2 ? r_h[SLOT_BITS-1:0] : r_rem;
    end

    always_comb begin
        n_state = r_state;
        n_type  = r_type;
        n_key   = r_key;
        n_h     = r_h;
        n_step  = r_step;
        n_phase = r_phase;
        n_q     = r_q;
        n_r     = r_r;
        n_rem   = r_rem;
        i_req.ready  = 1'b0;
        o_push_valid = 1'b0;
        o_push_data.req_type = r_type;
        o_push_data.key      = r_key;
        o_push_data.start    = MAX_SLOT_BITS'(w_start);

        case (r_state)
            F_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_type = i_req.req_type;
                    n_key.radius    = i_req.radius;
                    n_key.thickness = i_req.thickness;
                    n_key.colour    = {i_req.red, i_req.green, i_req.blue, i_req.alpha};
                    n_h     = FNV_BASIS;
                    n_step  = 3'd0;
                    n_phase = 2'd0;
                    n_state = (i_req.req_type == REQ_CLEAR) ? F_PUSH : F_HASH;
                end
            end
            F_HASH: begin
                n_h    = w_h_next;
                n_step = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = POW2 ? F_PUSH : F_MOD;
                end
            end
            F_MOD: begin
                // reciprocal quotient estimate, remainder, then one correction subtract
                if (r_phase == 2'd0) begin
                    n_q = w_prod[63:32];
                end else if (r_phase == 2'd1) begin
                    n_r = r_h - w_qs;
                end else begin
                    n_rem = (r_r >= 32'(SLOTS)) ? SLOT_BITS'(r_r - 32'(SLOTS))
                                                : SLOT_BITS'(r_r);
                end
                n_phase = r_phase + 2'd1;
                if (r_phase == 2'd2) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/hlkc_fifo.sv
// Two-entry request queue between the front end and the table engine.
// Depends on nothing; payload width is a parameter.
module hlkc_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data,
    output logic [1:0]       o_level
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign o_level      = r_cnt;
    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

FILE: hdl/hlkc_back.sv
// Table engine: linear probe, LRU scan, insert/stamp, clear sweep, response register.
// Depends on hlkc_pkg and hlkc_rsp_if; key and stamp tables are local memories.
module hlkc_back #(
    parameter int unsigned SLOTS      = hlkc_pkg::DEF_SLOTS,
    parameter int unsigned STAMP_BITS = hlkc_pkg::DEF_STAMP_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  hlkc_pkg::t_req i_pop_data,
    hlkc_rsp_if.source     o_rsp
);
    import hlkc_pkg::*;

    localparam int unsigned SLOT_BITS = $clog2(SLOTS);
    localparam int unsigned KEY_BITS  = $bits(t_key);
    localparam logic [SLOT_BITS-1:0] LAST = SLOT_BITS'(SLOTS - 1);

    // entry: {valid, key}
    logic [KEY_BITS:0]     key_mem   [SLOTS];
    logic [STAMP_BITS-1:0] stamp_mem [SLOTS];
    logic [KEY_BITS:0]     r_key_rd;
    logic [STAMP_BITS-1:0] r_stamp_rd;

    t_back_state r_state, n_state;
    t_key                  r_key, n_key;
    logic [SLOT_BITS-1:0]  r_idx, n_idx;
    logic [SLOT_BITS-1:0]  r_cnt, n_cnt;
    logic [SLOT_BITS-1:0]  r_tgt, n_tgt;
    logic [STAMP_BITS-1:0] r_min, n_min;
    logic [STAMP_BITS-1:0] r_ctr, n_ctr;
    logic                  r_hit, n_hit;
    logic                  r_evict, n_evict;
    logic                  r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic [6:0]            r_out_slot, n_out_slot;
    logic                  r_out_evict, n_out_evict;

    logic                  w_key_we, w_stamp_we;
    logic [KEY_BITS:0]     w_key_wd;
    logic [SLOT_BITS-1:0]  w_idx_inc;
    logic                  w_less;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_idx       <= '0;
            r_ctr       <= STAMP_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
        end
        r_key       <= n_key;
        r_cnt       <= n_cnt;
        r_tgt       <= n_tgt;
        r_min       <= n_min;
        r_hit       <= n_hit;
        r_evict     <= n_evict;
        r_clr       <= n_clr;
        r_out_hit   <= n_out_hit;
        r_out_slot  <= n_out_slot;
        r_out_evict <= n_out_evict;
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            key_mem[r_idx] <= w_key_wd;
        end
        if (w_stamp_we) begin
            stamp_mem[r_idx] <= r_ctr;
        end
        r_key_rd   <= key_mem[r_idx];
        r_stamp_rd <= stamp_mem[r_idx];
    end

    assign w_key_we   = (r_state == B_CLEAR) || (r_state == B_WRITE && !r_hit);
    assign w_stamp_we = (r_state == B_WRITE);
    assign w_key_wd   = (r_state == B_CLEAR) ? '0 : {1'b1, r_key};
    assign w_idx_inc  = (r_idx == LAST) ? '0 : r_idx + SLOT_BITS'(1);
    assign w_less     = (r_idx == '0) || (r_stamp_rd < r_min);

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.hit     = r_out_hit;
    assign o_rsp.slot    = r_out_slot;
    assign o_rsp.evicted = r_out_evict;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_tgt       = r_tgt;
        n_min       = r_min;
        n_ctr       = r_ctr;
        n_hit       = r_hit;
        n_evict     = r_evict;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_hit   = r_out_hit;
        n_out_slot  = r_out_slot;
        n_out_evict = r_out_evict;
        o_pop_ready = 1'b0;

        case (r_state)
            B_CLEAR: begin
                n_idx = w_idx_inc;
                if (r_idx == LAST) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_key   = i_pop_data.key;
                    n_hit   = 1'b0;
                    n_evict = 1'b0;
                    n_cnt   = '0;
                    if (i_pop_data.req_type == REQ_CLEAR) begin
                        n_clr   = 1'b1;
                        n_idx   = '0;
                        n_state = B_DONE;
                    end else begin
                        n_clr   = 1'b0;
                        n_idx   = i_pop_data.start[SLOT_BITS-1:0];
                        n_state = B_PROBE_RD;
                    end
                end
            end
            B_PROBE_RD: begin
                n_state = B_PROBE_CHK;
            end
            B_PROBE_CHK: begin
                if (!r_key_rd[KEY_BITS]) begin
                    n_state = B_WRITE;
                end else if (r_key_rd[KEY_BITS-1:0] == r_key) begin
                    n_hit   = 1'b1;
                    n_state = B_WRITE;
                end else if (r_cnt == LAST) begin
                    n_idx   = '0;
                    n_state = B_SCAN_RD;
                end else begin
                    n_idx   = w_idx_inc;
                    n_cnt   = r_cnt + SLOT_BITS'(1);
                    n_state = B_PROBE_RD;
                end
            end
            B_SCAN_RD: begin
                n_state = B_SCAN_CHK;
            end
            B_SCAN_CHK: begin
                // strict compare keeps the lowest index on ties
                if (w_less) begin
                    n_min = r_stamp_rd;
                    n_tgt = r_idx;
                end
                if (r_idx == LAST) begin
                    n_idx   = w_less ? r_idx : r_tgt;
                    n_evict = 1'b1;
                    n_state = B_WRITE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = B_SCAN_RD;
                end
            end
            B_WRITE: begin
                n_ctr   = r_ctr + STAMP_BITS'(1);
                n_state = B_DONE;
            end
            B_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_slot  = SLOT_OUT_BITS'(r_idx);
                    n_out_evict = r_evict;
                    if (r_clr) begin
                        n_ctr   = STAMP_BITS'(1);
                        n_idx   = '0;
                        n_state = B_CLEAR;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/hashed_lru_key_cache_unit.sv
// Hashed LRU key cache. The front end hashes a lookup's key and reduces it to a start
// slot (a modulo step only when SLOTS is not a power of two); the engine probes slot
// by slot and, when the table is full without a hit, scans the stamps for the victim.
// A clear is answered before its sweep. Each stage takes a request only when idle.
// Reset (i_rst_n low, synchronous) and each clear request start a sweep of the valid
// bits, during which no request is taken by the engine.
module hashed_lru_key_cache_unit #(
    parameter int unsigned SLOTS      = hlkc_pkg::DEF_SLOTS,
    parameter int unsigned STAMP_BITS = hlkc_pkg::DEF_STAMP_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hlkc_req_if.sink   i_req,
    hlkc_rsp_if.source o_rsp
);
    import hlkc_pkg::*;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    t_req       push_data, pop_data;
    logic [1:0] fifo_level;

    hlkc_front #(.SLOTS(SLOTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    hlkc_fifo #(.WIDTH($bits(t_req))) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data),
        .o_level      (fifo_level)
    );

    hlkc_back #(.SLOTS(SLOTS), .STAMP_BITS(STAMP_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.hit |-> !o_rsp.evicted)
        else $error("hit reported together with eviction");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_level != 2'd3)
        else $error("request queue level out of range");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("response valid right after reset");
`endif

endmodule
